### hw/rtl/ecpr_pkg.sv
// Shared types and constants for the enhanced clock page replacement core.
`default_nettype none

package ecpr_pkg;

    localparam int FRAMES    = 4;
    localparam int PAGE_BITS = 20;
    localparam int IDX_BITS  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PASS_BITS = 2;

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [IDX_BITS-1:0]  frame_t;

    typedef struct packed {
        page_t page_number;
        logic  is_write;
    } ref_item_t;

    typedef struct packed {
        logic   hit;
        frame_t frame_index;
        logic   replaced_valid;
        page_t  replaced_page;
        logic   replaced_dirty;
        frame_t next_hand;
    } res_item_t;

    // One frame table entry as held in memory.
    typedef struct packed {
        page_t tag;
        logic  use_bit;
        logic  mod_bit;
    } entry_t;

    typedef struct packed {
        frame_t rd_addr;
        logic   wr_en;
        frame_t wr_addr;
        entry_t wr_data;
    } mem_req_t;

    localparam frame_t LAST_FRAME = frame_t'(FRAMES - 1);

    function automatic frame_t next_frame(input frame_t f);
        next_frame = (f == LAST_FRAME) ? '0 : frame_t'(f + 1'b1);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ecpr_frame_mem.sv
// Frame table memory: one write port, one registered read port.
`default_nettype none

module ecpr_frame_mem (
    input  wire logic              clk,
    input  wire ecpr_pkg::mem_req_t req,
    output ecpr_pkg::entry_t       rd_data
);
    import ecpr_pkg::*;

    entry_t mem [FRAMES];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

endmodule

`default_nettype wire

### hw/rtl/ecpr_seq.sv
// Reference sequencer: tag search, four-pass victim scan, table updates.
`default_nettype none

module ecpr_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire ecpr_pkg::ref_item_t ref_item,
    input  wire logic               out_free,
    input  wire ecpr_pkg::entry_t   rd_data,
    output ecpr_pkg::mem_req_t      mem_req,
    output logic                    idle,
    output logic                    done,
    output ecpr_pkg::res_item_t     result
);
    import ecpr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HREAD = 3'd1;
    localparam logic [2:0] S_HCMP  = 3'd2;
    localparam logic [2:0] S_SREAD = 3'd3;
    localparam logic [2:0] S_SCMP  = 3'd4;

    logic [2:0]           state_reg, state_next;
    page_t                page_reg, page_next;
    logic                 wr_reg, wr_next;
    frame_t               idx_reg, idx_next;
    frame_t               step_reg, step_next;
    logic [PASS_BITS-1:0] pass_reg, pass_next;
    frame_t               hand_reg, hand_next;
    logic [FRAMES-1:0]    valid_reg, valid_next;

    logic ent_valid;
    logic eff_use;
    logic eff_mod;

    assign ent_valid = valid_reg[idx_reg];
    assign eff_use   = ent_valid & rd_data.use_bit;
    assign eff_mod   = ent_valid & rd_data.mod_bit;
    assign idle      = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        page_next  = page_reg;
        wr_next    = wr_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        pass_next  = pass_reg;
        hand_next  = hand_reg;
        valid_next = valid_reg;

        mem_req.rd_addr = idx_reg;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = idx_reg;
        mem_req.wr_data = rd_data;

        done                  = 1'b0;
        result.hit            = 1'b0;
        result.frame_index    = idx_reg;
        result.replaced_valid = 1'b0;
        result.replaced_page  = '0;
        result.replaced_dirty = 1'b0;
        result.next_hand      = hand_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    page_next  = ref_item.page_number;
                    wr_next    = ref_item.is_write;
                    idx_next   = '0;
                    state_next = S_HREAD;
                end
            end
            S_HREAD:
            begin
                state_next = S_HCMP;
            end
            S_HCMP:
            begin
                if (ent_valid && (rd_data.tag == page_reg))
                begin
                    if (out_free)
                    begin
                        mem_req.wr_en           = 1'b1;
                        mem_req.wr_data.use_bit = 1'b1;
                        mem_req.wr_data.mod_bit = rd_data.mod_bit | wr_reg;
                        done                    = 1'b1;
                        result.hit              = 1'b1;
                        state_next              = S_IDLE;
                    end
                end
                else if (idx_reg == LAST_FRAME)
                begin
                    idx_next   = hand_reg;
                    step_next  = '0;
                    pass_next  = '0;
                    state_next = S_SREAD;
                end
                else
                begin
                    idx_next   = next_frame(idx_reg);
                    state_next = S_HREAD;
                end
            end
            S_SREAD:
            begin
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (!eff_use && (eff_mod == pass_reg[0]))
                begin
                    if (out_free)
                    begin
                        mem_req.wr_en           = 1'b1;
                        mem_req.wr_data.tag     = page_reg;
                        mem_req.wr_data.use_bit = 1'b1;
                        mem_req.wr_data.mod_bit = wr_reg;
                        valid_next[idx_reg]     = 1'b1;
                        hand_next               = next_frame(idx_reg);
                        done                    = 1'b1;
                        result.replaced_valid   = ent_valid;
                        result.replaced_page    = ent_valid ? rd_data.tag : '0;
                        result.replaced_dirty   = eff_mod;
                        result.next_hand        = next_frame(idx_reg);
                        state_next              = S_IDLE;
                    end
                end
                else
                begin
                    // odd passes clear use on every frame they pass
                    if (pass_reg[0])
                    begin
                        mem_req.wr_en           = 1'b1;
                        mem_req.wr_data.use_bit = 1'b0;
                    end
                    idx_next = next_frame(idx_reg);
                    if (step_reg == LAST_FRAME)
                    begin
                        step_next = '0;
                        pass_next = pass_reg + 1'b1;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                    state_next = S_SREAD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
            pass_reg  <= '0;
            hand_reg  <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            pass_reg  <= pass_next;
            hand_reg  <= hand_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
        wr_reg   <= wr_next;
    end

endmodule

`default_nettype wire

### hw/rtl/enhanced_clock_page_replacement_core.sv
// Top level of the enhanced second-chance clock page replacement core.
//
// Each beat on the ref channel is one page reference (page number plus a
// write flag); each beat on the res channel reports where that page now
// lives: hit or miss, its frame, the evicted page and whether it was dirty,
// and the clock hand afterwards. References are handled one at a time.
// The frame table (tag, use, modify per frame) sits in a small synchronous
// memory with a registered read, and every frame visit is an address state
// followed by a compare and write-back state. The tag search runs upward
// from frame 0; a miss first searches all FRAMES tags and then scans from
// the hand. The scan ends at the latest on the first frame of its fourth
// pass, since the second pass leaves every use bit clear.
// A finished result goes into an output register, so the next reference is
// taken while the previous result waits on res_stall.
`default_nettype none

module enhanced_clock_page_replacement_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // reference channel
    input  wire logic                ref_valid,
    output logic                     ref_stall,
    input  wire ecpr_pkg::ref_item_t ref_item,
    // result channel
    output logic                     res_valid,
    input  wire logic                res_stall,
    output ecpr_pkg::res_item_t      res_item
);
    import ecpr_pkg::*;

    mem_req_t  mem_req;
    entry_t    rd_data;
    logic      seq_idle;
    logic      seq_done;
    logic      start;
    logic      out_free;
    res_item_t seq_result;

    logic      res_valid_reg, res_valid_next;
    res_item_t res_item_reg;

    // a new reference is taken only while the sequencer is idle
    assign ref_stall = !seq_idle;
    assign start     = ref_valid && !ref_stall;

    // output register can take a result when empty or being drained
    assign out_free = !res_valid_reg || !res_stall;

    ecpr_frame_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    ecpr_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .ref_item (ref_item),
        .out_free (out_free),
        .rd_data  (rd_data),
        .mem_req  (mem_req),
        .idle     (seq_idle),
        .done     (seq_done),
        .result   (seq_result)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (seq_done)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload, loaded only when the sequencer finishes a beat
    always_ff @(posedge clk)
    begin
        if (seq_done)
        begin
            res_item_reg <= seq_result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

`default_nettype wire

### verif/tb_enhanced_clock_page_replacement_core.sv
// Self-checking testbench for the enhanced clock page replacement core.
module tb_enhanced_clock_page_replacement_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ecpr_pkg::*;

    // Receiver stall behavior, with the mode re-picked at random.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_e;

    localparam int RANDOM_CHUNK   = 700;  // two chunks, a full drain between them
    localparam int LONG_HOLD      = 150;  // receiver hold-off that backs up the core
    localparam int HOLD_AT_RESULT = 300;  // result count that triggers the hold-off
    localparam int SETTLE_CYCLES  = 50;   // idle time before the final verdict

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      ref_valid = 1'b0;
    logic      ref_stall;
    ref_item_t ref_item  = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res_item;

    enhanced_clock_page_replacement_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ref_valid (ref_valid),
        .ref_stall (ref_stall),
        .ref_item  (ref_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Reset held low from the start, released on a falling edge, never again.
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Frame table predictor: its own copy of tags, valid, use, modify and
    // the clock hand, advanced once per accepted reference beat.
    // ------------------------------------------------------------------
    page_t  frame_page [FRAMES];
    logic   frame_loaded [FRAMES];
    logic   frame_used [FRAMES];
    logic   frame_dirty [FRAMES];
    frame_t hand_pos;

    initial
    begin
        for (int f = 0; f < FRAMES; f++)
        begin
            frame_page[f]   = '0;
            frame_loaded[f] = 1'b0;
            frame_used[f]   = 1'b0;
            frame_dirty[f]  = 1'b0;
        end
        hand_pos = '0;
    end

    function automatic res_item_t place_page(input ref_item_t r);
        res_item_t o;
        int        victim;
        int        idx;
        int        pass;
        int        step;
        o      = '0;
        victim = -1;
        // Hit: only loaded frames can match; hand stays put.
        for (int f = 0; f < FRAMES; f++)
        begin
            if (frame_loaded[f] && frame_page[f] == r.page_number)
            begin
                frame_used[f] = 1'b1;
                if (r.is_write)
                    frame_dirty[f] = 1'b1;
                o.hit         = 1'b1;
                o.frame_index = frame_t'(f);
                o.next_hand   = hand_pos;
                return o;
            end
        end
        // Miss: even passes look for clean unused frames, odd passes for
        // dirty unused ones and clear use bits on the frames they skip.
        for (pass = 0; pass < 4 && victim < 0; pass++)
        begin
            for (step = 0; step < FRAMES && victim < 0; step++)
            begin
                idx = (int'(hand_pos) + step) % FRAMES;
                if (!frame_used[idx] && frame_dirty[idx] == pass[0])
                    victim = idx;
                else if (pass[0])
                    frame_used[idx] = 1'b0;
            end
        end
        if (victim < 0)
            victim = int'(hand_pos);
        o.frame_index = frame_t'(victim);
        if (frame_loaded[victim])
        begin
            o.replaced_valid = 1'b1;
            o.replaced_page  = frame_page[victim];
            o.replaced_dirty = frame_dirty[victim];
        end
        frame_page[victim]   = r.page_number;
        frame_loaded[victim] = 1'b1;
        frame_used[victim]   = 1'b1;
        frame_dirty[victim]  = r.is_write;
        hand_pos             = frame_t'((victim + 1) % FRAMES);
        o.next_hand          = hand_pos;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus queue, expected placements, bookkeeping
    // ------------------------------------------------------------------
    ref_item_t pending_refs[$];
    res_item_t expected_placements[$];
    int        mismatch_count  = 0;
    int        placements_seen = 0;
    logic      ref_taken       = 1'b0;

    task automatic push_ref(input page_t page, input logic wr);
        ref_item_t r;
        r.page_number = page;
        r.is_write    = wr;
        pending_refs.push_back(r);
    endtask

    // Mostly a small working set around FRAMES pages so hits, clean and
    // dirty evictions and the use-clearing passes all come up; the rest is
    // fully random pages and back-to-back repeats.
    task automatic queue_random_refs(input int count);
        page_t pool [8];
        int    pool_size;
        int    pick;
        page_t page;
        page_t prev_page;
        pool_size = 4;
        prev_page = '0;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                pool_size = $urandom_range(2, 8);
                for (int p = 0; p < 8; p++)
                    pool[p] = page_t'($urandom);
            end
            pick = $urandom_range(0, 19);
            if (pick < 2)
                page = page_t'($urandom);
            else if (pick < 4)
                page = prev_page;
            else
                page = pool[$urandom_range(0, pool_size - 1)];
            push_ref(page, 1'($urandom_range(0, 1)));
            prev_page = page;
        end
    endtask

    // Idle means nothing queued, nothing offered and nothing outstanding.
    // Sampled on the rising edge so the driver's updates have settled.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_refs.size() != 0 || ref_valid || expected_placements.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of beats with random gaps; payload held while stalled
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            ref_valid <= 1'b0;
        else if (ref_valid && !ref_taken)
            ;  // beat still waiting, keep it steady
        else if (gap_left > 0)
        begin
            gap_left--;
            ref_valid <= 1'b0;
        end
        else if (pending_refs.size() > 0)
        begin
            ref_item  <= pending_refs.pop_front();
            ref_valid <= 1'b1;
            if (burst_left > 1)
                burst_left--;
            else
            begin
                // now and then a long burst with no idling at all
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 16);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
        else
            ref_valid <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern, with one long hold-off that lets the core
    // fill its output register and push back on the reference channel
    // ------------------------------------------------------------------
    stall_mode_e stall_mode     = STALL_NONE;
    int          mode_left      = 0;
    int          hold_left      = 0;
    bit          long_hold_done = 1'b0;
    logic [2:0]  stall_phase    = '0;

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_e'($urandom_range(0, 3));
            mode_left  = $urandom_range(32, 256);
        end
        else
            mode_left--;
        if (!long_hold_done && placements_seen >= HOLD_AT_RESULT)
        begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
        end
        stall_phase = stall_phase + 3'd1;
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                STALL_NONE:     res_stall <= 1'b0;
                STALL_LIGHT:    res_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    res_stall <= ($urandom_range(0, 9) < 7);
                STALL_PERIODIC: res_stall <= (stall_phase < 3'd3);
                default:        res_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted reference, check each result beat
    // against the oldest expected placement
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        ref_taken <= ref_valid && !ref_stall;
        if (rst_n && ref_valid && !ref_stall)
            expected_placements.push_back(place_page(ref_item));
        if (rst_n && res_valid && !res_stall)
        begin
            placements_seen++;
            if (expected_placements.size() == 0)
            begin
                $error("result beat with no reference outstanding: %h", res_item);
                mismatch_count++;
            end
            else
            begin
                res_item_t exp_r;
                exp_r = expected_placements.pop_front();
                check_field("hit", 32'(exp_r.hit), 32'(res_item.hit));
                check_field("frame_index", 32'(exp_r.frame_index),
                            32'(res_item.frame_index));
                check_field("replaced_valid", 32'(exp_r.replaced_valid),
                            32'(res_item.replaced_valid));
                check_field("replaced_page", 32'(exp_r.replaced_page),
                            32'(res_item.replaced_page));
                check_field("replaced_dirty", 32'(exp_r.replaced_dirty),
                            32'(res_item.replaced_dirty));
                check_field("next_hand", 32'(exp_r.next_hand),
                            32'(res_item.next_hand));
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        do
            @(posedge clk);
        while (!rst_n);

        // Directed: page 0 into an empty frame (tag zero must not hit),
        // extremes of the page field, hits in every frame, a write hit
        // that dirties a clean page, then misses with all use bits set
        // (use-clearing pass, later passes), clean and dirty evictions.
        push_ref(20'h00000, 1'b0);
        push_ref(20'hFFFFF, 1'b1);
        push_ref(20'h00000, 1'b0);
        push_ref(20'h00000, 1'b1);
        push_ref(20'h12345, 1'b0);
        push_ref(20'hABCDE, 1'b1);
        push_ref(20'hFFFFF, 1'b0);
        push_ref(20'hABCDE, 1'b0);
        push_ref(20'h12345, 1'b0);
        push_ref(20'h55555, 1'b0);
        push_ref(20'hAAAAA, 1'b0);
        push_ref(20'h55555, 1'b1);
        push_ref(20'h0F0F0, 1'b1);
        push_ref(20'hF0F0F, 1'b0);
        push_ref(20'h00001, 1'b1);
        push_ref(20'h80000, 1'b0);
        push_ref(20'h7FFFF, 1'b1);
        push_ref(20'h00000, 1'b0);
        push_ref(20'hFFFFF, 1'b0);
        push_ref(20'h80000, 1'b1);
        push_ref(20'h00001, 1'b0);
        wait_idle();

        // Random part; the sender pauses for a full drain between chunks.
        queue_random_refs(RANDOM_CHUNK);
        wait_idle();
        queue_random_refs(RANDOM_CHUNK);
        wait_idle();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: ends the run as failed far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
